// File: rtl/core/pspa_pkg.sv
// Shared constants, codes and types of the particle slot pool allocator.
package pspa_pkg;

    // Pool geometry and time field width.
    localparam int POOL_SLOTS = 64;
    localparam int TIME_BITS  = 16;
    localparam int SLOT_BITS  = $clog2(POOL_SLOTS);
    localparam int CNT_BITS   = $clog2(POOL_SLOTS + 1);

    // Configuration register layout.
    localparam int CFG_W   = 6;
    localparam int IDX_W   = 2;
    localparam int SUM_W   = CFG_W + 1;
    localparam int END_W   = (SUM_W > CNT_BITS) ? SUM_W : CNT_BITS;

    // Result field widths.
    localparam int OUT_SLOT_W = 6;
    localparam int OUT_CNT_W  = 7;

    localparam logic [IDX_W-1:0] REG_ALPHA = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_ADDIT = IDX_W'(1);
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

    localparam logic REQ_EMIT = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // One slot as seen by the replacement search.
    typedef struct packed {
        logic                 valid;
        logic                 in_group;
        logic                 active;
        logic [SLOT_BITS-1:0] idx;
        logic [TIME_BITS-1:0] age;
        logic [TIME_BITS-1:0] life;
    } t_cand;

    // Outcome of the replacement search.
    typedef struct packed {
        logic                 found;
        logic                 free;
        logic [SLOT_BITS-1:0] idx;
    } t_pick;

endpackage

// File: rtl/core/pspa_victim.sv
// Slot search for emits: first free slot, else the one furthest through its life.
module pspa_victim
    import pspa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_clear,
    input  t_cand i_cand,
    output t_pick o_pick
);

    logic                   r_found;
    logic                   r_free;
    logic [SLOT_BITS-1:0]   r_idx;
    logic [TIME_BITS-1:0]   r_num;
    logic [TIME_BITS-1:0]   r_den;

    logic [TIME_BITS-1:0]   num;
    logic [TIME_BITS-1:0]   den;
    logic [2*TIME_BITS-1:0] prod_new;
    logic [2*TIME_BITS-1:0] prod_best;
    logic                   look;

    // A zero lifetime counts as a ratio of exactly one.
    always_comb begin
        if (i_cand.life != '0) begin
            num = i_cand.age;
            den = i_cand.life;
        end else begin
            num = TIME_BITS'(1);
            den = TIME_BITS'(1);
        end
        prod_new  = (2*TIME_BITS)'(num) * (2*TIME_BITS)'(r_den);
        prod_best = (2*TIME_BITS)'(r_num) * (2*TIME_BITS)'(den);
        look      = i_cand.valid && i_cand.in_group && !r_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_free  <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
            r_free  <= 1'b0;
        end else if (look) begin
            if (!i_cand.active) begin
                r_found <= 1'b1;
                r_free  <= 1'b1;
                r_idx   <= i_cand.idx;
            end else if (!r_found || (prod_new > prod_best)) begin
                // Strictly greater keeps the earliest slot on ties.
                r_found <= 1'b1;
                r_idx   <= i_cand.idx;
                r_num   <= num;
                r_den   <= den;
            end
        end
    end

    assign o_pick.found = r_found;
    assign o_pick.free  = r_free;
    assign o_pick.idx   = r_idx;

endmodule

// File: rtl/core/particle_slot_pool_allocator_unit.sv
// Top level of the particle slot pool allocator.
//
// A request is taken when i_start is high while o_busy is low. Every request,
// emit or tick, walks the whole pool of POOL_SLOTS slots through the age and
// lifetime memory, one slot per cycle on its single read port, so o_busy stays
// high through the scan state, the drain state in which the last read lands
// and the commit state. The result appears on the o_ ports for exactly one
// cycle, marked by o_valid, in the first cycle that o_busy is low again;
// there is no back-pressure, so the receiver must take it then. A new request
// may be started in that same cycle. Configuration writes are always accepted
// (o_cfg_ready is held high) and must only be issued while the block is idle.
module particle_slot_pool_allocator_unit
    import pspa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request channel.
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_req_type,
    input  logic                  i_additive,
    input  logic [TIME_BITS-1:0]  i_lifetime,
    input  logic [TIME_BITS-1:0]  i_tick_time,
    // Result channel.
    output logic                  o_valid,
    output logic [OUT_SLOT_W-1:0] o_slot,
    output logic                  o_took_free,
    output logic [OUT_CNT_W-1:0]  o_expired_count,
    output logic [OUT_CNT_W-1:0]  o_live_count,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic [TIME_BITS-1:0] life;
        logic [TIME_BITS-1:0] age;
    } t_entry;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]      r_alpha;
    logic [CFG_W-1:0]      r_addit;
    logic                  r_req;
    logic                  r_add;
    logic [TIME_BITS-1:0]  r_life;
    logic [TIME_BITS-1:0]  r_dt;

    logic [SLOT_BITS-1:0]  r_rd_idx;
    logic                  r_pv;
    logic [SLOT_BITS-1:0]  r_pidx;
    logic [POOL_SLOTS-1:0] r_active;
    logic [CNT_BITS-1:0]   r_live;
    logic [CNT_BITS-1:0]   r_expired;

    logic                  r_done;
    logic [OUT_SLOT_W-1:0] r_o_slot;
    logic                  r_o_free;
    logic [OUT_CNT_W-1:0]  r_o_exp;
    logic [OUT_CNT_W-1:0]  r_o_live;

    // Age and lifetime store; the active flags live in flip-flops so that
    // reset clears them at once and the store needs no clearing pass.
    t_entry                mem [POOL_SLOTS];
    t_entry                r_rdata;

    logic                  accept;
    logic [END_W-1:0]      a_eff;
    logic [END_W-1:0]      b_eff;
    logic [END_W-1:0]      a_sum;
    logic [END_W-1:0]      alpha_end;
    logic [END_W-1:0]      pool_end;
    logic [END_W-1:0]      grp_lo;
    logic [END_W-1:0]      grp_hi;
    logic [END_W-1:0]      p_ext;
    logic                  in_use;
    logic                  in_group;
    logic                  p_active;
    logic                  is_emit;
    logic                  tick_on;
    logic [TIME_BITS:0]    age_sum;
    logic [TIME_BITS-1:0]  new_age;
    logic                  upd;
    logic                  retire;
    logic                  commit_emit;
    logic                  we;
    logic [SLOT_BITS-1:0]  waddr;
    t_entry                wdata;
    t_cand                 cand;
    t_pick                 pick;

    assign accept      = i_start && !o_busy;
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Group bounds: a zero register acts as one, and both ends clip to the pool.
    always_comb begin
        a_eff     = (r_alpha == '0) ? END_W'(1) : END_W'(r_alpha);
        b_eff     = (r_addit == '0) ? END_W'(1) : END_W'(r_addit);
        a_sum     = a_eff + b_eff;
        alpha_end = (a_eff > END_W'(POOL_SLOTS)) ? END_W'(POOL_SLOTS) : a_eff;
        pool_end  = (a_sum > END_W'(POOL_SLOTS)) ? END_W'(POOL_SLOTS) : a_sum;
        grp_lo    = r_add ? alpha_end : '0;
        grp_hi    = r_add ? pool_end : alpha_end;
    end

    // Slot whose memory data is on r_rdata this cycle.
    always_comb begin
        p_ext    = END_W'(r_pidx);
        in_use   = (p_ext < pool_end);
        in_group = (p_ext >= grp_lo) && (p_ext < grp_hi);
        p_active = r_active[r_pidx];
        is_emit  = (r_req == REQ_EMIT);
        tick_on  = (r_req == REQ_TICK) && (r_dt != '0);
        age_sum  = {1'b0, r_rdata.age} + {1'b0, r_dt};
        new_age  = age_sum[TIME_BITS] ? '1 : age_sum[TIME_BITS-1:0];
        upd      = r_pv && tick_on && p_active && in_use;
        retire   = upd && (new_age >= r_rdata.life);
    end

    assign cand.valid    = r_pv && is_emit;
    assign cand.in_group = in_group;
    assign cand.active   = p_active;
    assign cand.idx      = r_pidx;
    assign cand.age      = r_rdata.age;
    assign cand.life     = r_rdata.life;

    pspa_victim u_victim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (accept),
        .i_cand  (cand),
        .o_pick  (pick)
    );

    assign commit_emit = (r_state == S_COMMIT) && is_emit && pick.found;

    // One write port: ticks write back aged slots during the scan, an emit
    // writes its chosen slot in the commit cycle. The two never coincide.
    always_comb begin
        we    = upd || commit_emit;
        waddr = upd ? r_pidx : pick.idx;
        if (upd) begin
            wdata.life = r_rdata.life;
            wdata.age  = new_age;
        end else begin
            wdata.life = r_life;
            wdata.age  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[r_rd_idx];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_idx == SLOT_BITS'(POOL_SLOTS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_alpha  <= CFG_RESET;
            r_addit  <= CFG_RESET;
            r_pv     <= 1'b0;
            r_active <= '0;
            r_done   <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_SCAN);
            r_done  <= (r_state == S_COMMIT);

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_ALPHA) begin
                    r_alpha <= i_cfg_data;
                end else if (i_cfg_index == REG_ADDIT) begin
                    r_addit <= i_cfg_data;
                end
            end

            if (accept) begin
                r_rd_idx <= '0;
            end else if (r_state == S_SCAN) begin
                r_rd_idx <= r_rd_idx + SLOT_BITS'(1);
            end

            if (retire) begin
                r_active[r_pidx] <= 1'b0;
            end
            if (commit_emit) begin
                r_active[pick.idx] <= 1'b1;
            end
        end
    end

    // Request capture, live and retire counting, and the result registers.
    always_ff @(posedge i_clk) begin
        r_pidx <= r_rd_idx;
        if (accept) begin
            r_req     <= i_req_type;
            r_add     <= i_additive;
            r_life    <= i_lifetime;
            r_dt      <= i_tick_time;
            r_live    <= '0;
            r_expired <= '0;
        end else if (r_pv) begin
            if (in_use && p_active && !retire) begin
                r_live <= r_live + CNT_BITS'(1);
            end
            if (retire) begin
                r_expired <= r_expired + CNT_BITS'(1);
            end
        end

        if (r_state == S_COMMIT) begin
            // An emit into a free slot adds one live slot; a replacement
            // keeps the count, and the chosen slot always lies in use.
            if (is_emit) begin
                r_o_slot <= pick.found ? OUT_SLOT_W'(pick.idx) : '0;
                r_o_free <= pick.found && pick.free;
                r_o_exp  <= '0;
                r_o_live <= OUT_CNT_W'(r_live + CNT_BITS'(pick.found && pick.free));
            end else begin
                r_o_slot <= '0;
                r_o_free <= 1'b0;
                r_o_exp  <= OUT_CNT_W'(r_expired);
                r_o_live <= OUT_CNT_W'(r_live);
            end
        end
    end

    assign o_valid         = r_done;
    assign o_slot          = r_o_slot;
    assign o_took_free     = r_o_free;
    assign o_expired_count = r_o_exp;
    assign o_live_count    = r_o_live;

endmodule

// File: rtl/core/pspa_checker.sv
// Port-level checks of the particle slot pool allocator, bound to its top level.
module pspa_checker
    import pspa_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_start,
    input logic                  o_busy,
    input logic                  o_valid,
    input logic [OUT_SLOT_W-1:0] o_slot,
    input logic                  o_took_free,
    input logic [OUT_CNT_W-1:0]  o_expired_count
);

    // A result is shown only once the block has finished its transaction.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe while busy");

    // An accepted transaction keeps the block busy in the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not make the block busy");

    // Each transaction gives one single-cycle result.
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    // An emit into a free slot retires nothing.
    a_free_no_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_took_free) |-> (o_expired_count == '0))
        else $error("emit result carries an expired count");

    // A tick that retired slots reports no slot.
    a_exp_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_expired_count != '0)) |-> ((o_slot == '0) && !o_took_free))
        else $error("tick result carries slot fields");

endmodule

bind particle_slot_pool_allocator_unit pspa_checker u_pspa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_valid         (o_valid),
    .o_slot          (o_slot),
    .o_took_free     (o_took_free),
    .o_expired_count (o_expired_count)
);

// File: dv/tb.sv
// Self-checking testbench of the particle slot pool allocator top level.
`timescale 1ns / 100ps

module tb;
    import pspa_pkg::*;

    // A request keeps the block busy for a full pool scan plus the drain and commit states.
    localparam int SCAN_CYCLES = POOL_SLOTS + 3;
    localparam int TAIL_CYCLES = SCAN_CYCLES + 8;
    localparam int CYCLE_LIMIT = 700_000;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 123;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};
    // Indexes past the register list; writes to them must be dropped.
    localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(3);

    typedef enum {
        STEP_REQUEST,
        STEP_REG_WRITE,
        STEP_PACE,
        STEP_DRAIN
    } t_step;

    typedef struct {
        t_step                kind;
        logic                 req_type;
        logic                 additive;
        logic [TIME_BITS-1:0] lifetime;
        logic [TIME_BITS-1:0] tick_time;
        logic [IDX_W-1:0]     reg_index;
        logic [CFG_W-1:0]     reg_data;
        int unsigned          idle_pct;
    } t_plan_entry;

    typedef struct packed {
        logic [OUT_SLOT_W-1:0] slot;
        logic                  took_free;
        logic [OUT_CNT_W-1:0]  expired;
        logic [OUT_CNT_W-1:0]  live;
    } t_pool_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  o_busy;
    logic                  i_req_type = REQ_EMIT;
    logic                  i_additive = 1'b0;
    logic [TIME_BITS-1:0]  i_lifetime = '0;
    logic [TIME_BITS-1:0]  i_tick_time = '0;
    logic                  o_valid;
    logic [OUT_SLOT_W-1:0] o_slot;
    logic                  o_took_free;
    logic [OUT_CNT_W-1:0]  o_expired_count;
    logic [OUT_CNT_W-1:0]  o_live_count;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [IDX_W-1:0]      i_cfg_index = REG_ALPHA;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    particle_slot_pool_allocator_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_req_type      (i_req_type),
        .i_additive      (i_additive),
        .i_lifetime      (i_lifetime),
        .i_tick_time     (i_tick_time),
        .o_valid         (o_valid),
        .o_slot          (o_slot),
        .o_took_free     (o_took_free),
        .o_expired_count (o_expired_count),
        .o_live_count    (o_live_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the pool and its group split.
    logic                 shadow_active [POOL_SLOTS];
    logic [TIME_BITS-1:0] shadow_age    [POOL_SLOTS];
    logic [TIME_BITS-1:0] shadow_life   [POOL_SLOTS];
    logic [CFG_W-1:0]     shadow_alpha = CFG_RESET;
    logic [CFG_W-1:0]     shadow_addit = CFG_RESET;

    t_plan_entry  plan_q[$];
    t_pool_result awaited_results[$];
    t_plan_entry  cur_entry;
    logic         have_entry = 1'b0;
    int unsigned  sender_idle_pct = 0;
    int unsigned  taken_count = 0;
    int unsigned  taken_seen = 0;
    int unsigned  cycle_count = 0;
    int unsigned  mismatches = 0;

    initial begin
        for (int i = 0; i < POOL_SLOTS; i++) begin
            shadow_active[i] = 1'b0;
            shadow_age[i]    = '0;
            shadow_life[i]   = '0;
        end
    end

    // A zero group size behaves as one slot; both bounds clip to the pool.
    function automatic int unsigned group_size(logic [CFG_W-1:0] raw);
        return (raw == '0) ? 1 : int'(raw);
    endfunction

    function automatic int unsigned clip_to_pool(int unsigned v);
        return (v > POOL_SLOTS) ? POOL_SLOTS : v;
    endfunction

    // Applies one emit or tick to the shadow pool and returns what the block
    // should report for it.
    function automatic t_pool_result allocate_or_age(logic req_type, logic additive,
                                                     logic [TIME_BITS-1:0] lifetime,
                                                     logic [TIME_BITS-1:0] tick_time);
        t_pool_result     res;
        int unsigned      alpha_end;
        int unsigned      pool_end;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      pick;
        int unsigned      expired;
        int unsigned      live;
        logic             found;
        logic             done;
        longint unsigned  best_num;
        longint unsigned  best_den;
        longint unsigned  num;
        longint unsigned  den;
        int unsigned      sum;
        alpha_end = clip_to_pool(group_size(shadow_alpha));
        pool_end  = clip_to_pool(group_size(shadow_alpha) + group_size(shadow_addit));
        res      = '0;
        expired  = 0;
        if (req_type == REQ_EMIT) begin
            lo       = additive ? alpha_end : 0;
            hi       = additive ? pool_end : alpha_end;
            found    = 1'b0;
            done     = 1'b0;
            pick     = 0;
            best_num = 0;
            best_den = 1;
            // First free slot wins; otherwise the one furthest through its life,
            // the earliest on a tie. A zero lifetime reads as fully through.
            for (int unsigned i = lo; i < hi && !done; i++) begin
                if (!shadow_active[i]) begin
                    pick  = i;
                    found = 1'b1;
                    done  = 1'b1;
                end else begin
                    if (shadow_life[i] != '0) begin
                        num = shadow_age[i];
                        den = shadow_life[i];
                    end else begin
                        num = 1;
                        den = 1;
                    end
                    if (!found || num * best_den > best_num * den) begin
                        best_num = num;
                        best_den = den;
                        pick     = i;
                        found    = 1'b1;
                    end
                end
            end
            if (found) begin
                res.slot      = OUT_SLOT_W'(pick);
                res.took_free = !shadow_active[pick];
                shadow_active[pick] = 1'b1;
                shadow_age[pick]    = '0;
                shadow_life[pick]   = lifetime;
            end
        end else if (tick_time != '0) begin
            for (int unsigned i = 0; i < pool_end; i++) begin
                if (shadow_active[i]) begin
                    sum = int'(shadow_age[i]) + int'(tick_time);
                    shadow_age[i] = (sum > int'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(sum);
                    if (shadow_age[i] >= shadow_life[i]) begin
                        shadow_active[i] = 1'b0;
                        expired++;
                    end
                end
            end
        end
        live = 0;
        for (int unsigned i = 0; i < pool_end; i++)
            live += shadow_active[i] ? 1 : 0;
        res.expired = OUT_CNT_W'(expired);
        res.live    = OUT_CNT_W'(live);
        return res;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: results are compared first, then any transaction accepted at
    // this edge updates the shadow state.
    always @(posedge i_clk) begin
        t_pool_result want;
        cycle_count++;
        if (i_rst_n) begin
            if (o_valid) begin
                if (awaited_results.size() == 0) begin
                    $error("result with nothing awaited: slot %0d live %0d",
                           o_slot, o_live_count);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("slot", want.slot, o_slot);
                    check_field("took_free", want.took_free, o_took_free);
                    check_field("expired_count", want.expired, o_expired_count);
                    check_field("live_count", want.live, o_live_count);
                end
            end
            if (i_start && !o_busy) begin
                awaited_results.push_back(allocate_or_age(i_req_type, i_additive,
                                                          i_lifetime, i_tick_time));
                taken_count++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_ALPHA)
                    shadow_alpha = i_cfg_data;
                else if (i_cfg_index == REG_ADDIT)
                    shadow_addit = i_cfg_data;
                taken_count++;
            end
        end
    end

    // Driver: works through the plan, one transaction at a time, and idles
    // at random by the current pace. Every input gets one assignment per edge.
    always @(negedge i_clk) begin
        logic go;
        logic nxt_start;
        logic nxt_cfg_valid;
        go            = 1'b1;
        nxt_start     = 1'b0;
        nxt_cfg_valid = 1'b0;
        if (taken_count != taken_seen) begin
            have_entry = 1'b0;
            taken_seen = taken_count;
        end
        if (i_rst_n) begin
            while (go && !have_entry && plan_q.size() > 0) begin
                case (plan_q[0].kind)
                    STEP_PACE: begin
                        sender_idle_pct = plan_q[0].idle_pct;
                        void'(plan_q.pop_front());
                    end
                    STEP_DRAIN: begin
                        if (awaited_results.size() == 0)
                            void'(plan_q.pop_front());
                        else
                            go = 1'b0;
                    end
                    default: begin
                        cur_entry  = plan_q.pop_front();
                        have_entry = 1'b1;
                    end
                endcase
            end
        end
        if (have_entry) begin
            if (cur_entry.kind == STEP_REQUEST)
                nxt_start = ($urandom_range(99) >= sender_idle_pct);
            else
                nxt_cfg_valid = ($urandom_range(99) >= sender_idle_pct);
        end
        i_start     <= nxt_start;
        i_cfg_valid <= nxt_cfg_valid;
        i_req_type  <= cur_entry.req_type;
        i_additive  <= cur_entry.additive;
        i_lifetime  <= cur_entry.lifetime;
        i_tick_time <= cur_entry.tick_time;
        i_cfg_index <= cur_entry.reg_index;
        i_cfg_data  <= cur_entry.reg_data;
    end

    // Plan builders. Fields that a request does not use carry random noise.
    task automatic plan_emit(logic additive, logic [TIME_BITS-1:0] lifetime);
        t_plan_entry e;
        e = '{kind: STEP_REQUEST, req_type: REQ_EMIT, additive: additive,
              lifetime: lifetime, tick_time: TIME_BITS'($urandom),
              reg_index: IDX_W'($urandom), reg_data: CFG_W'($urandom), idle_pct: 0};
        plan_q.push_back(e);
    endtask

    task automatic plan_tick(logic [TIME_BITS-1:0] tick_time);
        t_plan_entry e;
        e = '{kind: STEP_REQUEST, req_type: REQ_TICK, additive: 1'($urandom),
              lifetime: TIME_BITS'($urandom), tick_time: tick_time,
              reg_index: IDX_W'($urandom), reg_data: CFG_W'($urandom), idle_pct: 0};
        plan_q.push_back(e);
    endtask

    // A register write always waits for the block to go idle first.
    task automatic plan_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] data);
        t_plan_entry e;
        e = '{kind: STEP_DRAIN, req_type: REQ_EMIT, additive: 1'b0, lifetime: '0,
              tick_time: '0, reg_index: index, reg_data: data, idle_pct: 0};
        plan_q.push_back(e);
        e.kind = STEP_REG_WRITE;
        plan_q.push_back(e);
    endtask

    task automatic plan_pace(int unsigned pct);
        t_plan_entry e;
        e = '{kind: STEP_PACE, req_type: REQ_EMIT, additive: 1'b0, lifetime: '0,
              tick_time: '0, reg_index: REG_ALPHA, reg_data: '0, idle_pct: pct};
        plan_q.push_back(e);
    endtask

    function automatic logic [CFG_W-1:0] pick_group_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        else if (r < 35)
            return CFG_W'(1);
        else if (r < 65)
            return CFG_W'($urandom_range(4, 2));
        else if (r < 80)
            return CFG_MAX;
        else
            return CFG_W'($urandom);
    endfunction

    initial begin
        int unsigned r;
        int unsigned pace_list [3];
        logic [TIME_BITS-1:0] value;
        pace_list = '{0, 76, 15};

        // Directed part, starting from the reset split of 32 and 32.
        plan_pace(0);
        plan_tick('0);                  // zero tick on an empty pool
        plan_emit(1'b0, '0);            // zero lifetime
        plan_emit(1'b1, TIME_MAX);
        plan_emit(1'b0, TIME_BITS'(1));
        plan_tick('0);                  // zero tick leaves ages alone
        plan_tick(TIME_BITS'(1));       // zero lifetime retires on first tick
        plan_tick(TIME_MAX);            // age saturates at the field maximum
        plan_reg(REG_ALPHA, '0);        // zero size acts as one slot
        plan_reg(REG_ADDIT, '0);
        plan_emit(1'b0, TIME_BITS'(10));
        plan_emit(1'b0, TIME_BITS'(20)); // group full: replacement
        plan_emit(1'b1, '0);
        plan_emit(1'b1, TIME_BITS'(5)); // replaces the zero-lifetime slot
        plan_reg(REG_ALPHA, CFG_W'(3));
        plan_reg(REG_ADDIT, CFG_MAX);   // total clipped to the pool
        plan_emit(1'b0, TIME_BITS'(4));
        plan_emit(1'b0, TIME_BITS'(2)); // all ages zero: earliest slot wins
        plan_tick(TIME_BITS'(1));
        plan_emit(1'b0, TIME_BITS'(7)); // cross-multiplied comparison
        plan_emit(1'b1, TIME_MAX);
        plan_reg(REG_SPARE_LO, CFG_MAX);        // ignored write
        plan_reg(REG_SPARE_HI, CFG_W'(6'h2a));  // ignored write
        plan_tick(TIME_BITS'(3));
        plan_emit(1'b0, TIME_BITS'(1));
        plan_reg(REG_ALPHA, CFG_MAX);
        plan_reg(REG_ADDIT, CFG_MAX);
        plan_emit(1'b1, TIME_BITS'(100));
        plan_tick(TIME_MAX);

        // Random phases: a fresh split and pace each time, then a mix that
        // leans on short lifetimes and small ticks so groups fill and turn over.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            plan_reg(REG_ALPHA, pick_group_size());
            plan_reg(REG_ADDIT, pick_group_size());
            if ($urandom_range(2) == 0)
                plan_reg(IDX_W'($urandom_range(3, 2)), CFG_W'($urandom));
            plan_pace(pace_list[p % 3]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(99);
                if (r < 65) begin
                    r = $urandom_range(99);
                    if (r < 8)
                        value = '0;
                    else if (r < 60)
                        value = TIME_BITS'($urandom_range(200, 1));
                    else if (r < 92)
                        value = TIME_BITS'($urandom);
                    else
                        value = TIME_MAX;
                    plan_emit(1'($urandom), value);
                end else begin
                    r = $urandom_range(99);
                    if (r < 6)
                        value = '0;
                    else if (r < 70)
                        value = TIME_BITS'($urandom_range(64, 1));
                    else if (r < 95)
                        value = TIME_BITS'($urandom);
                    else
                        value = TIME_MAX;
                    plan_tick(value);
                end
            end
        end

        // Synchronous reset held from the start, released on a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (plan_q.size() != 0 || have_entry || awaited_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Run limit: several times the slowest correct run.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: particle_slot_pool_allocator_unit.f
rtl/core/pspa_pkg.sv
rtl/core/pspa_victim.sv
rtl/core/particle_slot_pool_allocator_unit.sv
rtl/core/pspa_checker.sv
dv/tb.sv
